// ===== rtl/core/sbq_pkg.sv =====
// ----------------------------------------------------------------------------
// sbq_pkg
// Shared types and constants for the stereo direct form I biquad core.
// ----------------------------------------------------------------------------
package sbq_pkg;

  // Sample and coefficient formats: Q1.23 samples, Q4.20 coefficients.
  localparam int SAMPLE_BITS  = 24;
  localparam int COEFF_BITS   = 24;
  localparam int LANES        = 2;

  // Five products of SAMPLE_BITS x COEFF_BITS plus headroom for the sum.
  localparam int PROD_BITS    = SAMPLE_BITS + COEFF_BITS;
  localparam int ACC_BITS     = PROD_BITS + 3;
  localparam int DIV_CNT_BITS = $clog2(ACC_BITS + 1);

  // Number of multiply-accumulate terms per sample.
  localparam int MAC_TERMS    = 5;
  localparam int MAC_CNT_BITS = $clog2(MAC_TERMS + 1);

  // Configuration port.
  localparam int CFG_ADDR_BITS = 3;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A0 = 3'd3,
    REG_A1 = 3'd4,
    REG_A2 = 3'd5
  } reg_idx_t;

  localparam logic signed [COEFF_BITS-1:0] B0_RESET = COEFF_BITS'(1048576);
  localparam logic signed [COEFF_BITS-1:0] A0_RESET = COEFF_BITS'(1048576);

  // Coefficient set shared by all lanes.
  typedef struct packed {
    logic signed [COEFF_BITS-1:0] b0;
    logic signed [COEFF_BITS-1:0] b1;
    logic signed [COEFF_BITS-1:0] b2;
    logic signed [COEFF_BITS-1:0] a0;
    logic signed [COEFF_BITS-1:0] a1;
    logic signed [COEFF_BITS-1:0] a2;
  } coef_t;

  // Status and result of one lane toward the merging stage.
  typedef struct packed {
    logic                          done;
    logic                          err;
    logic signed [SAMPLE_BITS-1:0] y;
  } lane_res_t;

  // Stream payload widths; the divisor error flag travels in tuser.
  localparam int IN_BITS   = LANES * SAMPLE_BITS;
  localparam int IN_BYTES  = (IN_BITS + 7) / 8;
  localparam int OUT_BITS  = LANES * SAMPLE_BITS;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

endpackage

// ===== rtl/core/stereo_biquad_iir_filter_core.sv =====
// ----------------------------------------------------------------------------
// stereo_biquad_iir_filter_core
// Stereo direct form I biquad with two parallel lanes and a merging stage.
// ----------------------------------------------------------------------------
// Sequence from an accepted input transaction to the output transaction:
// serial multiply-accumulate, one divider setup state, the one-bit-per-cycle
// divider in each lane, then sequencing and merge. A new input frame is taken
// only after the previous result has entered the output register.
// Reset (synchronous, active high) clears the histories and loads the
// coefficient defaults b0 = a0 = 1.0, all others zero.
// ----------------------------------------------------------------------------
module stereo_biquad_iir_filter_core (
  input  logic                                   clk,
  input  logic                                   rst,
  // Input stream, tdata: left_sample, right_sample.
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [sbq_pkg::IN_BYTES*8-1:0]         s_tdata,
  // Output stream, tdata: left_result, right_result.
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  output logic [sbq_pkg::OUT_BYTES*8-1:0]        m_tdata,
  // Output stream, tuser: divisor_error.
  output logic                                   m_tuser,
  // Configuration write port.
  input  logic                                   cfg_we,
  input  logic [sbq_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
  input  logic [sbq_pkg::COEFF_BITS-1:0]         cfg_wdata
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_RUN  = 3'b010,
    T_WAIT = 3'b100
  } top_state_t;

  localparam int SB = sbq_pkg::SAMPLE_BITS;
  localparam int NL = sbq_pkg::LANES;

  top_state_t          state;
  sbq_pkg::coef_t      coef;
  sbq_pkg::lane_res_t  lane_res [NL];
  logic [NL-1:0]       lane_done;
  logic [NL-1:0]       done_now;
  logic                start;
  logic                any_err;
  logic [NL*SB-1:0]    merged;
  logic                out_free;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef.b0 <= sbq_pkg::B0_RESET;
      coef.b1 <= '0;
      coef.b2 <= '0;
      coef.a0 <= sbq_pkg::A0_RESET;
      coef.a1 <= '0;
      coef.a2 <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sbq_pkg::REG_B0: coef.b0 <= cfg_wdata;
        sbq_pkg::REG_B1: coef.b1 <= cfg_wdata;
        sbq_pkg::REG_B2: coef.b2 <= cfg_wdata;
        sbq_pkg::REG_A0: coef.a0 <= cfg_wdata;
        sbq_pkg::REG_A1: coef.a1 <= cfg_wdata;
        sbq_pkg::REG_A2: coef.a2 <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign s_tready = (state == T_IDLE);
  assign start    = s_tvalid && s_tready;

  // Filter lanes, one per channel.
  for (genvar g = 0; g < NL; g++) begin : g_lane
    sbq_lane u_lane (
      .clk   (clk),
      .rst   (rst),
      .start (start),
      .x     (s_tdata[g*SB +: SB]),
      .coef  (coef),
      .res   (lane_res[g])
    );
    assign done_now[g] = lane_res[g].done;
  end

  // Merge: an error in any lane zeroes every result.
  always_comb begin
    any_err = 1'b0;
    for (int i = 0; i < NL; i++) begin
      any_err = any_err | lane_res[i].err;
    end
    for (int i = 0; i < NL; i++) begin
      merged[i*SB +: SB] = any_err ? '0 : lane_res[i].y;
    end
  end

  assign out_free = !m_tvalid || m_tready;

  // Frame sequencing and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      lane_done <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // A merged frame refills the output slot; otherwise an accept empties it.
      if ((state == T_WAIT) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (start) begin
            lane_done <= '0;
            state     <= T_RUN;
          end
        end
        T_RUN: begin
          lane_done <= lane_done | done_now;
          if ((lane_done | done_now) == {NL{1'b1}}) begin
            state <= T_WAIT;
          end
        end
        T_WAIT: begin
          if (out_free) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == T_WAIT) && out_free) begin
      m_tdata <= (sbq_pkg::OUT_BYTES*8)'(merged);
      m_tuser <= any_err;
    end
  end

endmodule

// ===== rtl/core/sbq_divider.sv =====
// ----------------------------------------------------------------------------
// sbq_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sbq_divider (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [sbq_pkg::ACC_BITS-1:0]         dividend,
  input  logic [sbq_pkg::COEFF_BITS-1:0]       divisor,
  output logic                                 done,
  output logic [sbq_pkg::ACC_BITS-1:0]         quotient
);

  logic [sbq_pkg::COEFF_BITS-1:0]   rem;
  logic [sbq_pkg::COEFF_BITS-1:0]   rem_next;
  logic [sbq_pkg::ACC_BITS-1:0]     dvd;
  logic [sbq_pkg::COEFF_BITS-1:0]   den;
  logic [sbq_pkg::DIV_CNT_BITS-1:0] cnt;
  logic                             busy;
  logic [sbq_pkg::COEFF_BITS:0]     trial;
  logic [sbq_pkg::COEFF_BITS:0]     diff;
  logic                             qbit;

  // Shift in the next dividend bit and try a subtraction.
  always_comb begin
    trial    = {rem, dvd[sbq_pkg::ACC_BITS-1]};
    diff     = trial - {1'b0, den};
    qbit     = (trial >= {1'b0, den});
    rem_next = qbit ? diff[sbq_pkg::COEFF_BITS-1:0] : trial[sbq_pkg::COEFF_BITS-1:0];
  end

  // Iteration control; done pulses once after the last quotient bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !start && busy && (cnt == sbq_pkg::DIV_CNT_BITS'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= sbq_pkg::DIV_CNT_BITS'(sbq_pkg::ACC_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == sbq_pkg::DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvd      <= dividend;
      den      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= rem_next;
      dvd      <= {dvd[sbq_pkg::ACC_BITS-2:0], 1'b0};
      quotient <= {quotient[sbq_pkg::ACC_BITS-2:0], qbit};
    end
  end

endmodule

// ===== rtl/core/sbq_lane.sv =====
// ----------------------------------------------------------------------------
// sbq_lane
// One channel of the biquad: history, serial MAC and divide with saturation.
// ----------------------------------------------------------------------------
module sbq_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [sbq_pkg::SAMPLE_BITS-1:0] x,
  input  sbq_pkg::coef_t                       coef,
  output sbq_pkg::lane_res_t                   res
);

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MAC  = 4'b0010,
    L_PREP = 4'b0100,
    L_DIV  = 4'b1000
  } lane_state_t;

  localparam int SB = sbq_pkg::SAMPLE_BITS;
  localparam int CB = sbq_pkg::COEFF_BITS;
  localparam int AB = sbq_pkg::ACC_BITS;
  localparam int PB = sbq_pkg::PROD_BITS;

  lane_state_t                     state;
  logic [sbq_pkg::MAC_CNT_BITS-1:0] cnt;
  logic signed [SB-1:0]            x_q;
  logic signed [SB-1:0]            x1;
  logic signed [SB-1:0]            x2;
  logic signed [SB-1:0]            y1;
  logic signed [SB-1:0]            y2;
  logic signed [CB-1:0]            op_c;
  logic signed [SB-1:0]            op_d;
  logic                            op_sub;
  logic signed [PB-1:0]            prod_q;
  logic                            prod_vld;
  logic                            prod_sub;
  logic signed [AB-1:0]            acc;
  logic signed [AB-1:0]            prod_ext;
  logic                            neg_q;
  logic [AB-1:0]                   acc_mag;
  logic [CB-1:0]                   den_mag;
  logic                            div_start;
  logic                            div_done;
  logic [AB-1:0]                   quo;
  logic signed [SB-1:0]            y_sat;

  // Operand selection for the shared multiplier.
  always_comb begin
    op_c   = '0;
    op_d   = '0;
    op_sub = 1'b0;
    unique case (cnt)
      3'd0:    begin op_c = coef.b0; op_d = x_q; end
      3'd1:    begin op_c = coef.b1; op_d = x1;  end
      3'd2:    begin op_c = coef.b2; op_d = x2;  end
      3'd3:    begin op_c = coef.a1; op_d = y1; op_sub = 1'b1; end
      3'd4:    begin op_c = coef.a2; op_d = y2; op_sub = 1'b1; end
      default: begin op_c = '0;      op_d = '0; end
    endcase
  end

  assign prod_ext = AB'(prod_q);

  // Magnitudes for the unsigned divider.
  always_comb begin
    acc_mag = acc[AB-1] ? AB'(-acc) : AB'(acc);
    den_mag = coef.a0[CB-1] ? CB'(-coef.a0) : CB'(coef.a0);
  end

  assign div_start = (state == L_PREP) && (coef.a0 != '0);

  sbq_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_mag),
    .divisor  (den_mag),
    .done     (div_done),
    .quotient (quo)
  );

  // Apply the sign and saturate the quotient to the sample range.
  always_comb begin
    if (neg_q) begin
      if ((quo[AB-1:SB] != '0) || (quo[SB-1] && (quo[SB-2:0] != '0))) begin
        y_sat = {1'b1, {(SB-1){1'b0}}};
      end else begin
        y_sat = SB'(-quo[SB-1:0]);
      end
    end else begin
      if (quo[AB-1:SB-1] != '0) begin
        y_sat = {1'b0, {(SB-1){1'b1}}};
      end else begin
        y_sat = SB'(quo[SB-1:0]);
      end
    end
  end

  // Multiply-accumulate pipeline: product register, then accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      x_q <= x;
      acc <= '0;
    end else if (state == L_MAC) begin
      if (cnt < sbq_pkg::MAC_CNT_BITS'(sbq_pkg::MAC_TERMS)) begin
        prod_q   <= op_c * op_d;
        prod_sub <= op_sub;
      end
      if (prod_vld) begin
        acc <= prod_sub ? (acc - prod_ext) : (acc + prod_ext);
      end
    end
    if (state == L_PREP) begin
      neg_q <= acc[AB-1] ^ coef.a0[CB-1];
    end
  end

  // Sequencer and history update.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= L_IDLE;
      cnt      <= '0;
      prod_vld <= 1'b0;
      res      <= '0;
      x1       <= '0;
      x2       <= '0;
      y1       <= '0;
      y2       <= '0;
    end else begin
      // A result is ready when a zero divisor skips the divide or the divider finishes.
      res.done <= ((state == L_PREP) && (coef.a0 == '0)) || ((state == L_DIV) && div_done);
      unique case (state)
        L_IDLE: begin
          if (start) begin
            state    <= L_MAC;
            cnt      <= '0;
            prod_vld <= 1'b0;
          end
        end
        L_MAC: begin
          cnt      <= cnt + 1'b1;
          prod_vld <= (cnt < sbq_pkg::MAC_CNT_BITS'(sbq_pkg::MAC_TERMS));
          if (cnt == sbq_pkg::MAC_CNT_BITS'(sbq_pkg::MAC_TERMS)) begin
            state <= L_PREP;
          end
        end
        L_PREP: begin
          // A zero divisor forces a zero output and flags the error.
          if (coef.a0 == '0) begin
            res.err  <= 1'b1;
            res.y    <= '0;
            x1       <= x_q;
            x2       <= x1;
            y1       <= '0;
            y2       <= y1;
            state    <= L_IDLE;
          end else begin
            state <= L_DIV;
          end
        end
        L_DIV: begin
          if (div_done) begin
            res.err  <= 1'b0;
            res.y    <= y_sat;
            x1       <= x_q;
            x2       <= x1;
            y1       <= y_sat;
            y2       <= y1;
            state    <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/sbq_checker.sv =====
// ----------------------------------------------------------------------------
// sbq_checker
// Port-level checks for the stereo biquad core, bound to the top level.
// ----------------------------------------------------------------------------
module sbq_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  input  logic                              s_tready,
  input  logic                              m_tvalid,
  input  logic                              m_tready,
  input  logic [sbq_pkg::OUT_BYTES*8-1:0]   m_tdata,
  input  logic                              m_tuser,
  input  logic                              cfg_we
);

  // One frame at a time: an accepted transaction closes the input side.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while a frame is in flight");

  // A stalled output transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("output payload changed while stalled");

  // A divisor error always comes with zeroed results.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("divisor error with nonzero results");

  // Leaving reset, the core is ready and holds no result.
  a_reset_state: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (s_tready && !m_tvalid))
    else $error("bad state after reset");

  // Coefficients must change only while no frame is in flight: a rule for the user that the core does not enforce.
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> (s_tready && !m_tvalid))
    else $error("configuration write while a frame is in flight");

endmodule

bind stereo_biquad_iir_filter_core sbq_checker u_sbq_checker (.*);
